### hw/rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token codes, character codes and helper functions of the
// source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 16;
    localparam int LEN_BITS        = 16;
    localparam int KIND_BITS       = 5;
    localparam int MAX_TOKENS      = 3;
    localparam int CNT_BITS        = 2;
    localparam int Q_DEPTH         = 4;
    localparam int WORD_BITS       = 48;
    localparam int KW_COUNT        = 7;
    localparam int KW_MAX_LEN      = 6;

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    localparam logic [KIND_BITS-1:0] KIND_EOF    = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_ERROR  = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_IDENT  = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_VAR    = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_SEMI   = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_COMMA  = 5'd16;
    localparam logic [KIND_BITS-1:0] KIND_PLUS   = 5'd17;
    localparam logic [KIND_BITS-1:0] KIND_MINUS  = 5'd18;
    localparam logic [KIND_BITS-1:0] KIND_STAR   = 5'd19;
    localparam logic [KIND_BITS-1:0] KIND_SLASH  = 5'd20;
    localparam logic [KIND_BITS-1:0] KIND_ASSIGN = 5'd21;
    localparam logic [KIND_BITS-1:0] KIND_GE     = 5'd28;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [1:0] OP_EQ   = 2'd0;
    localparam logic [1:0] OP_BANG = 2'd1;
    localparam logic [1:0] OP_LT   = 2'd2;
    localparam logic [1:0] OP_GT   = 2'd3;

    localparam logic [WORD_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        48'h00000076_6172,
        48'h00000066_756e,
        48'h00000000_6966,
        48'h0000656c_7365,
        48'h00776869_6c65,
        48'h72657475_726e,
        48'h00707269_6e74
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd3, 3'd2, 3'd4, 3'd5, 3'd6, 3'd5
    };

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_NUMDOT,
        MODE_FRAC,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_OP
    } t_mode;

    function automatic logic f_is_alpha(input logic [7:0] b);
        f_is_alpha = (b inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER});
    endfunction

    function automatic logic f_is_digit(input logic [7:0] b);
        f_is_digit = (b inside {[8'h30:8'h39]});
    endfunction

    function automatic logic f_is_sym(input logic [7:0] b);
        f_is_sym = (b inside {CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI,
                              CH_COMMA, CH_PLUS, CH_MINUS, CH_STAR});
    endfunction

    function automatic logic [KIND_BITS-1:0] f_sym_kind(input logic [7:0] b);
        case (b)
            CH_LPAREN: f_sym_kind = KIND_LPAREN;
            CH_RPAREN: f_sym_kind = KIND_RPAREN;
            CH_LBRACE: f_sym_kind = KIND_LBRACE;
            CH_RBRACE: f_sym_kind = KIND_RBRACE;
            CH_SEMI:   f_sym_kind = KIND_SEMI;
            CH_COMMA:  f_sym_kind = KIND_COMMA;
            CH_PLUS:   f_sym_kind = KIND_PLUS;
            CH_MINUS:  f_sym_kind = KIND_MINUS;
            CH_STAR:   f_sym_kind = KIND_STAR;
            default:   f_sym_kind = KIND_ERROR;
        endcase
    endfunction

    function automatic logic [1:0] f_op_code(input logic [7:0] b);
        case (b)
            CH_EQ:   f_op_code = OP_EQ;
            CH_BANG: f_op_code = OP_BANG;
            CH_LT:   f_op_code = OP_LT;
            CH_GT:   f_op_code = OP_GT;
            default: f_op_code = OP_EQ;
        endcase
    endfunction

    function automatic logic [KIND_BITS-1:0] f_word_kind(input logic [WORD_BITS-1:0] word,
                                                         input logic [2:0] len);
        logic [KIND_BITS-1:0] k;
        k = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (word == KW_TEXT[i] && len == KW_LEN[i]) begin
                k = KIND_VAR + KIND_BITS'(i);
            end
        end
        f_word_kind = k;
    endfunction

endpackage

### hw/rtl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Scanner front end: steps the lexer state on each accepted byte and hands
// the up to three tokens it closes or emits to the queue as one bundle.
// ----------------------------------------------------------------------------
module stt_front
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int BUN_W       = CNT_BITS + MAX_TOKENS *
                                (KIND_BITS + OFFSET_BITS + LEN_BITS + LINE_BITS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_text_byte,
    output logic             o_stall,
    input  logic             i_full,
    output logic             o_push,
    output logic [BUN_W-1:0] o_bundle
);

    localparam int SW = (OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] start;
        logic [LEN_BITS-1:0]    len;
        logic [LINE_BITS-1:0]   line;
    } t_token;

    typedef struct packed {
        logic [CNT_BITS-1:0] n;
        t_token [MAX_TOKENS-1:0] tok;
    } t_bundle;

    function automatic logic [LEN_BITS-1:0] f_clamp(input logic [OFFSET_BITS-1:0] d);
        logic [SW-1:0] w;
        w = SW'(d);
        f_clamp = (w > SW'(LEN_MAX)) ? LEN_MAX : w[LEN_BITS-1:0];
    endfunction

    t_mode                  r_mode, n_mode;
    logic [1:0]             r_op, n_op;
    logic [WORD_BITS-1:0]   r_word, n_word;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [LINE_BITS-1:0]   r_line, n_line;

    logic [7:0]             b;
    logic                   accept;
    logic                   alpha, digit, blank, opstart, sym;
    logic                   rescan;
    logic [OFFSET_BITS-1:0] dot_pos, span_p, span_d;
    logic [KIND_BITS-1:0]   word_kind;
    logic                   a_v, b_v, c_v;
    t_token                 a_tok, b_tok, c_tok;
    t_bundle                bun;

    assign b       = i_text_byte;
    assign accept  = i_valid && !o_stall;
    assign o_stall = i_full;

    assign alpha   = f_is_alpha(b);
    assign digit   = f_is_digit(b);
    assign blank   = (b inside {CH_SPACE, CH_CR, CH_TAB});
    assign opstart = (b inside {CH_EQ, CH_BANG, CH_LT, CH_GT});
    assign sym     = f_is_sym(b);

    assign dot_pos = (r_offset != '0) ? r_offset - OFFSET_BITS'(1) : '0;
    assign span_p  = (r_offset >= r_start) ? r_offset - r_start : '0;
    assign span_d  = (dot_pos >= r_start) ? dot_pos - r_start : '0;
    assign word_kind = (span_p <= OFFSET_BITS'(KW_MAX_LEN)) ?
                       f_word_kind(r_word, span_p[2:0]) : KIND_IDENT;

    // closing of the pending token, the fresh scan of the byte and the next state
    always_comb begin
        rescan      = 1'b1;
        a_v         = 1'b0;
        b_v         = 1'b0;
        a_tok.kind  = KIND_NUMBER;
        a_tok.start = r_start;
        a_tok.len   = f_clamp(span_p);
        a_tok.line  = r_line;
        b_tok.kind  = KIND_ERROR;
        b_tok.start = dot_pos;
        b_tok.len   = LEN_BITS'(1);
        b_tok.line  = r_line;
        case (r_mode)
            MODE_IDENT: begin
                if (alpha || digit) begin
                    rescan = 1'b0;
                end else begin
                    a_v        = 1'b1;
                    a_tok.kind = word_kind;
                end
            end
            MODE_NUM: begin
                if (digit || b == CH_DOT) begin
                    rescan = 1'b0;
                end else begin
                    a_v = 1'b1;
                end
            end
            MODE_NUMDOT: begin
                if (digit) begin
                    rescan = 1'b0;
                end else begin
                    a_v       = 1'b1;
                    a_tok.len = f_clamp(span_d);
                    b_v       = 1'b1;
                end
            end
            MODE_FRAC: begin
                if (digit) begin
                    rescan = 1'b0;
                end else begin
                    a_v = 1'b1;
                end
            end
            MODE_SLASH: begin
                if (b == CH_SLASH) begin
                    rescan = 1'b0;
                end else begin
                    a_v        = 1'b1;
                    a_tok.kind = KIND_SLASH;
                    a_tok.len  = LEN_BITS'(1);
                end
            end
            MODE_COMMENT: begin
                if (b != CH_NL && b != CH_NUL) begin
                    rescan = 1'b0;
                end
            end
            MODE_OP: begin
                a_v = 1'b1;
                if (b == CH_EQ) begin
                    rescan     = 1'b0;
                    a_tok.kind = KIND_ASSIGN + KIND_BITS'({r_op, 1'b1});
                    a_tok.len  = LEN_BITS'(2);
                end else begin
                    a_tok.kind = KIND_ASSIGN + KIND_BITS'({r_op, 1'b0});
                    a_tok.len  = LEN_BITS'(1);
                end
            end
            default: begin
            end
        endcase

        c_v         = 1'b0;
        c_tok.kind  = KIND_ERROR;
        c_tok.start = r_offset;
        c_tok.len   = LEN_BITS'(1);
        c_tok.line  = r_line;
        if (rescan) begin
            if (b == CH_NUL) begin
                c_v        = 1'b1;
                c_tok.kind = KIND_EOF;
                c_tok.len  = '0;
            end else if (sym) begin
                c_v        = 1'b1;
                c_tok.kind = f_sym_kind(b);
            end else if (!(blank || b == CH_NL || b == CH_SLASH || alpha || digit ||
                           opstart)) begin
                c_v = 1'b1;
            end
        end

        n_word = r_word;
        if (!rescan && r_mode == MODE_IDENT) begin
            n_word = {r_word[WORD_BITS-9:0], b};
        end else if (rescan && alpha) begin
            n_word = WORD_BITS'(b);
        end else if (rescan && b == CH_NUL) begin
            n_word = '0;
        end

        n_start = r_start;
        n_op    = r_op;
        n_line  = r_line;
        if (rescan) begin
            if (b == CH_NUL) begin
                n_start = '0;
                n_op    = OP_EQ;
                n_line  = LINE_BITS'(1);
            end else if (b == CH_NL) begin
                if (r_line < LINE_MAX) begin
                    n_line = r_line + LINE_BITS'(1);
                end
            end else if (!blank) begin
                n_start = r_offset;
                if (opstart) begin
                    n_op = f_op_code(b);
                end
            end
        end

        if (b == CH_NUL) begin
            n_offset = '0;
        end else if (r_offset < OFF_MAX) begin
            n_offset = r_offset + OFFSET_BITS'(1);
        end else begin
            n_offset = r_offset;
        end
    end

    // scan mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_NUM: begin
                if (b == CH_DOT) begin
                    n_mode = MODE_NUMDOT;
                end
            end
            MODE_NUMDOT: begin
                if (digit) begin
                    n_mode = MODE_FRAC;
                end
            end
            MODE_SLASH: begin
                if (b == CH_SLASH) begin
                    n_mode = MODE_COMMENT;
                end
            end
            MODE_OP: begin
                if (b == CH_EQ) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
            end
        endcase
        if (rescan) begin
            if (alpha) begin
                n_mode = MODE_IDENT;
            end else if (digit) begin
                n_mode = MODE_NUM;
            end else if (b == CH_SLASH) begin
                n_mode = MODE_SLASH;
            end else if (opstart) begin
                n_mode = MODE_OP;
            end else begin
                n_mode = MODE_IDLE;
            end
        end
    end

    // pack the tokens of this byte in order
    always_comb begin
        bun.n      = CNT_BITS'(a_v) + CNT_BITS'(b_v) + CNT_BITS'(c_v);
        bun.tok[0] = a_v ? a_tok : c_tok;
        bun.tok[1] = b_v ? b_tok : c_tok;
        bun.tok[2] = c_tok;
    end

    assign o_push   = accept && (a_v || c_v);
    assign o_bundle = bun;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_op     <= OP_EQ;
            r_word   <= '0;
            r_start  <= '0;
            r_offset <= '0;
            r_line   <= LINE_BITS'(1);
        end else if (accept) begin
            r_mode   <= n_mode;
            r_op     <= n_op;
            r_word   <= n_word;
            r_start  <= n_start;
            r_offset <= n_offset;
            r_line   <= n_line;
        end
    end

endmodule

### hw/rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Small first-in first-out buffer of token bundles between the scanner
// front end and the token output stage.
// ----------------------------------------------------------------------------
module stt_queue
    import stt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

### hw/rtl/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Token output stage: takes queued bundles and presents their tokens one per
// cycle unless stalled in a registered output, marking the last of each.
// ----------------------------------------------------------------------------
module stt_back
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int BUN_W       = CNT_BITS + MAX_TOKENS *
                                (KIND_BITS + OFFSET_BITS + LEN_BITS + LINE_BITS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  logic [BUN_W-1:0]       i_bundle,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [KIND_BITS-1:0]   o_token_kind,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [LEN_BITS-1:0]    o_token_length,
    output logic [LINE_BITS-1:0]   o_line_number,
    output logic                   o_last_of_run
);

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] start;
        logic [LEN_BITS-1:0]    len;
        logic [LINE_BITS-1:0]   line;
    } t_token;

    typedef struct packed {
        logic [CNT_BITS-1:0] n;
        t_token [MAX_TOKENS-1:0] tok;
    } t_bundle;

    t_bundle             r_bun;
    logic                r_have;
    logic [CNT_BITS-1:0] r_idx;
    t_token              r_out;
    logic                r_last;
    logic                r_valid;

    t_token              cur;
    logic                adv, last;

    always_comb begin
        case (r_idx)
            2'd0:    cur = r_bun.tok[0];
            2'd1:    cur = r_bun.tok[1];
            default: cur = r_bun.tok[2];
        endcase
    end

    assign adv   = r_have && (!r_valid || !i_stall);
    assign last  = (r_idx == r_bun.n - CNT_BITS'(1));
    assign o_pop = i_q_valid && (!r_have || (adv && last));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bun <= t_bundle'(i_bundle);
        end
        if (adv) begin
            r_out  <= cur;
            r_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have <= 1'b1;
                r_idx  <= '0;
            end else if (adv && last) begin
                r_have <= 1'b0;
            end else if (adv) begin
                r_idx <= r_idx + CNT_BITS'(1);
            end
            if (adv) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_token_kind   = r_out.kind;
    assign o_start_offset = r_out.start;
    assign o_token_length = r_out.len;
    assign o_line_number  = r_out.line;
    assign o_last_of_run  = r_last;

endmodule

### hw/rtl/source_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Lexical scanner for source text streamed one byte per request.
// ----------------------------------------------------------------------------
// The scanner takes one text byte per cycle while the queue has room and
// returns one token per cycle while the output is not stalled. A byte closes
// the pending token, which for a number followed by a dot and no digit gives
// both the number and an error token for the dot, and may emit one more token
// of its own, so it yields zero to three tokens; the scanner front end steps
// its registered state on each accepted byte and writes all tokens of a byte
// as one entry into a four-entry queue, and the output stage drains them one
// per cycle while not stalled through a registered output. A byte is thus
// taken every cycle while the queue has room; sustained, the rate is set by
// the output side at one token per cycle. A token passes the queue and the
// bundle and output registers of the output stage, waiting longer when tokens
// of earlier bytes are still waiting or the output is stalled. Byte 0 emits
// the end-of-text token and returns the scanner to its reset state.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_text_byte,
    output logic                   o_stall,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [KIND_BITS-1:0]   o_token_kind,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [LEN_BITS-1:0]    o_token_length,
    output logic [LINE_BITS-1:0]   o_line_number,
    output logic                   o_last_of_run
);

    localparam int TOK_W = KIND_BITS + OFFSET_BITS + LEN_BITS + LINE_BITS;
    localparam int BUN_W = CNT_BITS + MAX_TOKENS * TOK_W;

    logic             q_full, q_valid, q_push, q_pop;
    logic [BUN_W-1:0] q_wdata, q_rdata;

    stt_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .BUN_W       (BUN_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_text_byte (i_text_byte),
        .o_stall     (o_stall),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_bundle    (q_wdata)
    );

    stt_queue #(
        .WIDTH (BUN_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rdata)
    );

    stt_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .BUN_W       (BUN_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_bundle       (q_rdata),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_line_number  (o_line_number),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

### hw/rtl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the tokenizer output stream, bound to the top level.
// ----------------------------------------------------------------------------
module stt_checker
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_text_byte,
    input  logic                   o_stall,
    input  logic                   o_valid,
    input  logic                   i_stall,
    input  logic [KIND_BITS-1:0]   o_token_kind,
    input  logic [OFFSET_BITS-1:0] o_start_offset,
    input  logic [LEN_BITS-1:0]    o_token_length,
    input  logic [LINE_BITS-1:0]   o_line_number,
    input  logic                   o_last_of_run
);

    // stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_text_byte))
        else $error("stalled request changed");

    // stalled token holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) &&
        $stable(o_start_offset) && $stable(o_token_length) &&
        $stable(o_line_number) && $stable(o_last_of_run))
        else $error("stalled token changed");

    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == KIND_EOF |-> o_token_length == '0 && o_last_of_run)
        else $error("end-of-text token malformed");

    a_error_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == KIND_ERROR |-> o_token_length == LEN_BITS'(1))
        else $error("error token length not one");

    a_line_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_line_number != '0 && o_token_kind <= KIND_GE)
        else $error("token line or kind out of range");

endmodule

bind source_text_tokenizer_top stt_checker #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
) u_stt_checker (.*);
